@@ rtl/core/mbse_pkg.sv @@
// Shared types, constants and helpers for the smoothed Mandelbrot escape-time core.
package mbse_pkg;

    // Coordinate and product widths (Q4.28 operands, Q8.56 products)
    localparam int COORD_W = 32;
    localparam int PROD_W  = 64;
    localparam int IDX_W   = 9;
    localparam int ITER_W  = 12;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 3;

    // Width used for sums ahead of saturation
    localparam int SAT_W = 44;

    // 4.0 in Q8.56
    localparam logic [PROD_W-1:0] FOUR_Q56 = 64'h0400_0000_0000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_RE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_IM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 3'd6;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_RE,
        ST_C_IM,
        ST_C_SET,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CHECK,
        ST_UPDATE,
        ST_FRAC
    } state_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic in_range;
        in_range = (&v[SAT_W-1:COORD_W-1]) || !(|v[SAT_W-1:COORD_W-1]);
        if (in_range)
        begin
            return v[COORD_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ rtl/core/mbse_mul.sv @@
// Shared signed 32x32 multiplier with a registered 64-bit product.
module mbse_mul (
    input  logic                                  clk,
    input  logic signed [mbse_pkg::COORD_W-1:0]   op_a,
    input  logic signed [mbse_pkg::COORD_W-1:0]   op_b,
    output logic signed [mbse_pkg::PROD_W-1:0]    prod
);

    logic signed [mbse_pkg::PROD_W-1:0] prod_reg;
    logic signed [mbse_pkg::PROD_W-1:0] prod_next;

    // Full-precision product, one per cycle
    always_comb
    begin
        prod_next = mbse_pkg::PROD_W'(op_a) * mbse_pkg::PROD_W'(op_b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/mbse_frac_div.sv @@
// Bit-serial restoring divider for the smoothing fraction floor(2^16 * m / (m + 4)).
module mbse_frac_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mbse_pkg::PROD_W-1:0]         m,
    output logic                                done,
    output logic [mbse_pkg::FRAC_W-1:0]         q
);

    localparam int CNT_W = $clog2(mbse_pkg::FRAC_W);

    logic                              run_reg, run_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [mbse_pkg::PROD_W-1:0]       rem_reg, rem_next;
    logic [mbse_pkg::PROD_W-1:0]       den_reg, den_next;
    logic [mbse_pkg::FRAC_W-1:0]       q_reg, q_next;
    logic [mbse_pkg::PROD_W:0]         rem2;
    logic [mbse_pkg::PROD_W:0]         diff;

    // One quotient bit per cycle: double the remainder, subtract when it fits
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        rem2      = {rem_reg, 1'b0};
        diff      = rem2 - {1'b0, den_reg};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(mbse_pkg::FRAC_W - 1);
            rem_next = m;
            den_next = m + mbse_pkg::FOUR_Q56;
            q_next   = '0;
        end
        else if (run_reg)
        begin
            if (!diff[mbse_pkg::PROD_W])
            begin
                rem_next = diff[mbse_pkg::PROD_W-1:0];
                q_next   = {q_reg[mbse_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem2[mbse_pkg::PROD_W-1:0];
                q_next   = {q_reg[mbse_pkg::FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

@@ rtl/core/mandelbrot_smooth_escape_time.sv @@
// Top level: smoothed Mandelbrot escape time for one pixel per command.
//
// A pixel is taken when start is high and busy is low; its result appears on
// escape_count, escape_fraction and bad_window for exactly one cycle with done
// high, and must be captured then. All multiplies run through one registered
// 32x32 multiplier: c is formed in the C_RE, C_IM and C_SET states, and each
// iteration of z = z*z + c steps through re^2, im^2 with the escape test, re*im
// and update. An escaping pixel then gets its fraction from a bit-serial divide.
// A bad window answers in the cycle after the start beat. Configuration is
// written through cfg_wr_en/cfg_index/cfg_data, by the user only while idle;
// the block itself does not enforce this.
module mandelbrot_smooth_escape_time #(
    parameter int GRID_SIZE = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mbse_pkg::IDX_W-1:0]          column,
    input  logic [mbse_pkg::IDX_W-1:0]          row,
    input  logic                                cfg_wr_en,
    input  logic [mbse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbse_pkg::COORD_W-1:0]        cfg_data,
    output logic                                done,
    output logic [mbse_pkg::ITER_W-1:0]         escape_count,
    output logic [mbse_pkg::FRAC_W-1:0]         escape_fraction,
    output logic                                bad_window
);

    localparam int CMP_W = mbse_pkg::ITER_W + 1;
    localparam logic [CMP_W-1:0] GRID_LAST = CMP_W'(GRID_SIZE - 1);

    // Configuration registers
    logic signed [mbse_pkg::COORD_W-1:0] origin_re_reg, origin_im_reg;
    logic signed [mbse_pkg::COORD_W-1:0] step_re_reg, step_im_reg;
    logic signed [mbse_pkg::COORD_W-1:0] start_re_reg, start_im_reg;
    logic [mbse_pkg::ITER_W-1:0]         iter_lim_reg;

    // Sequencer and datapath
    mbse_pkg::state_t                    state_reg, state_next;
    logic [mbse_pkg::IDX_W-1:0]          col_reg, col_next;
    logic [mbse_pkg::IDX_W-1:0]          row_reg, row_next;
    logic signed [mbse_pkg::COORD_W-1:0] cre_reg, cre_next;
    logic signed [mbse_pkg::COORD_W-1:0] cim_reg, cim_next;
    logic signed [mbse_pkg::COORD_W-1:0] zre_reg, zre_next;
    logic signed [mbse_pkg::COORD_W-1:0] zim_reg, zim_next;
    logic signed [mbse_pkg::PROD_W-1:0]  sqre_reg, sqre_next;
    logic signed [mbse_pkg::PROD_W-1:0]  diff_reg, diff_next;
    logic [mbse_pkg::ITER_W-1:0]         iter_reg, iter_next;
    logic                                first_reg, first_next;
    logic                                done_reg, done_next;
    logic [mbse_pkg::ITER_W-1:0]         count_reg, count_next;
    logic [mbse_pkg::FRAC_W-1:0]         frac_reg, frac_next;
    logic                                bad_reg, bad_next;

    logic signed [mbse_pkg::COORD_W-1:0] op_a, op_b;
    logic signed [mbse_pkg::PROD_W-1:0]  prod;
    logic [mbse_pkg::PROD_W-1:0]         mag;
    logic                                div_start;
    logic                                div_done;
    logic [mbse_pkg::FRAC_W-1:0]         div_q;
    logic                                window_bad;
    logic [mbse_pkg::IDX_W-1:0]          col_clamped, row_clamped;
    logic signed [mbse_pkg::SAT_W-1:0]   c_re_sum, c_im_sum;
    logic signed [mbse_pkg::SAT_W-1:0]   z_re_sum, z_im_sum;
    logic [mbse_pkg::ITER_W-1:0]         iter_inc;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= -32'sd536870912;
            origin_im_reg <= -32'sd268435456;
            step_re_reg   <= 32'sd1048576;
            step_im_reg   <= 32'sd1048576;
            start_re_reg  <= '0;
            start_im_reg  <= '0;
            iter_lim_reg  <= 12'd498;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mbse_pkg::REG_ORIGIN_RE: origin_re_reg <= cfg_data;
                mbse_pkg::REG_ORIGIN_IM: origin_im_reg <= cfg_data;
                mbse_pkg::REG_STEP_RE:   step_re_reg   <= cfg_data;
                mbse_pkg::REG_STEP_IM:   step_im_reg   <= cfg_data;
                mbse_pkg::REG_START_RE:  start_re_reg  <= cfg_data;
                mbse_pkg::REG_START_IM:  start_im_reg  <= cfg_data;
                mbse_pkg::REG_ITER_LIM:  iter_lim_reg  <= cfg_data[mbse_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Window check and index clamp
    assign window_bad  = (step_re_reg <= 0) || (step_im_reg <= 0);
    assign col_clamped = ({{(CMP_W-mbse_pkg::IDX_W){1'b0}}, column} > GRID_LAST) ?
                         GRID_LAST[mbse_pkg::IDX_W-1:0] : column;
    assign row_clamped = ({{(CMP_W-mbse_pkg::IDX_W){1'b0}}, row} > GRID_LAST) ?
                         GRID_LAST[mbse_pkg::IDX_W-1:0] : row;

    // Sums ahead of saturation; c uses the small index*step product
    assign c_re_sum = {{(mbse_pkg::SAT_W-43){prod[42]}}, prod[42:0]}
                    + {{(mbse_pkg::SAT_W-mbse_pkg::COORD_W){origin_re_reg[31]}}, origin_re_reg};
    assign c_im_sum = {{(mbse_pkg::SAT_W-43){prod[42]}}, prod[42:0]}
                    + {{(mbse_pkg::SAT_W-mbse_pkg::COORD_W){origin_im_reg[31]}}, origin_im_reg};
    assign z_re_sum = {{(mbse_pkg::SAT_W-36){diff_reg[63]}}, diff_reg[63:28]}
                    + {{(mbse_pkg::SAT_W-mbse_pkg::COORD_W){cre_reg[31]}}, cre_reg};
    assign z_im_sum = {{(mbse_pkg::SAT_W-37){prod[63]}}, prod[63:27]}
                    + {{(mbse_pkg::SAT_W-mbse_pkg::COORD_W){cim_reg[31]}}, cim_reg};

    // |z|^2 once im^2 is on the product register
    assign mag      = sqre_reg + prod;
    assign iter_inc = iter_reg + 1'b1;

    // Multiplier operand selection
    always_comb
    begin
        unique case (state_reg)
            mbse_pkg::ST_C_RE:
            begin
                op_a = {{(mbse_pkg::COORD_W-mbse_pkg::IDX_W){1'b0}}, col_reg};
                op_b = step_re_reg;
            end
            mbse_pkg::ST_C_IM:
            begin
                op_a = {{(mbse_pkg::COORD_W-mbse_pkg::IDX_W){1'b0}}, row_reg};
                op_b = step_im_reg;
            end
            mbse_pkg::ST_SQ_RE:
            begin
                op_a = zre_reg;
                op_b = zre_reg;
            end
            mbse_pkg::ST_SQ_IM:
            begin
                op_a = zim_reg;
                op_b = zim_reg;
            end
            default:
            begin
                op_a = zre_reg;
                op_b = zim_reg;
            end
        endcase
    end

    mbse_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    mbse_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .m     (mag),
        .done  (div_done),
        .q     (div_q)
    );

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cre_next   = cre_reg;
        cim_next   = cim_reg;
        zre_next   = zre_reg;
        zim_next   = zim_reg;
        sqre_next  = sqre_reg;
        diff_next  = diff_reg;
        iter_next  = iter_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        frac_next  = frac_reg;
        bad_next   = bad_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            mbse_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    col_next = col_clamped;
                    row_next = row_clamped;
                    if (window_bad)
                    begin
                        done_next  = 1'b1;
                        bad_next   = 1'b1;
                        count_next = '0;
                        frac_next  = '0;
                    end
                    else
                    begin
                        state_next = mbse_pkg::ST_C_RE;
                    end
                end
            end
            mbse_pkg::ST_C_RE:
            begin
                state_next = mbse_pkg::ST_C_IM;
            end
            mbse_pkg::ST_C_IM:
            begin
                cre_next   = mbse_pkg::sat32(c_re_sum);
                state_next = mbse_pkg::ST_C_SET;
            end
            mbse_pkg::ST_C_SET:
            begin
                cim_next   = mbse_pkg::sat32(c_im_sum);
                zre_next   = start_re_reg;
                zim_next   = start_im_reg;
                iter_next  = '0;
                first_next = 1'b1;
                if (iter_lim_reg == '0)
                begin
                    done_next  = 1'b1;
                    bad_next   = 1'b0;
                    count_next = '0;
                    frac_next  = '0;
                    state_next = mbse_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mbse_pkg::ST_SQ_RE;
                end
            end
            mbse_pkg::ST_SQ_RE:
            begin
                state_next = mbse_pkg::ST_SQ_IM;
            end
            mbse_pkg::ST_SQ_IM:
            begin
                sqre_next  = prod;
                state_next = mbse_pkg::ST_CHECK;
            end
            mbse_pkg::ST_CHECK:
            begin
                // re^2 - im^2 kept for the update; re*im issued meanwhile
                diff_next = sqre_reg - prod;
                if (!first_reg && (mag > mbse_pkg::FOUR_Q56))
                begin
                    div_start  = 1'b1;
                    state_next = mbse_pkg::ST_FRAC;
                end
                else if (!first_reg && (iter_inc == iter_lim_reg))
                begin
                    done_next  = 1'b1;
                    bad_next   = 1'b0;
                    count_next = iter_lim_reg;
                    frac_next  = '0;
                    state_next = mbse_pkg::ST_IDLE;
                end
                else
                begin
                    if (!first_reg)
                    begin
                        iter_next = iter_inc;
                    end
                    first_next = 1'b0;
                    state_next = mbse_pkg::ST_UPDATE;
                end
            end
            mbse_pkg::ST_UPDATE:
            begin
                zre_next   = mbse_pkg::sat32(z_re_sum);
                zim_next   = mbse_pkg::sat32(z_im_sum);
                state_next = mbse_pkg::ST_SQ_RE;
            end
            mbse_pkg::ST_FRAC:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    bad_next   = 1'b0;
                    count_next = iter_reg;
                    frac_next  = div_q;
                    state_next = mbse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbse_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbse_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            first_reg <= first_next;
            iter_reg  <= iter_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        cre_reg   <= cre_next;
        cim_reg   <= cim_next;
        zre_reg   <= zre_next;
        zim_reg   <= zim_next;
        sqre_reg  <= sqre_next;
        diff_reg  <= diff_next;
        count_reg <= count_next;
        frac_reg  <= frac_next;
        bad_reg   <= bad_next;
    end

    assign busy            = (state_reg != mbse_pkg::ST_IDLE);
    assign done            = done_reg;
    assign escape_count    = count_reg;
    assign escape_fraction = frac_reg;
    assign bad_window      = bad_reg;

    // Result beat only shows while the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    // A taken start either answers at once or starts the sequence
    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted start produced neither work nor result");

    // Bad window clears the other fields
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_window) |-> (escape_count == '0 && escape_fraction == '0))
        else $error("bad window result with nonzero fields");

    // A nonzero fraction means escape before the limit
    a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && escape_fraction != '0) |-> (escape_count < iter_lim_reg))
        else $error("fraction reported without an escape");

endmodule
